// ===== rtl/core/swt_pkg.sv =====
package swt_pkg;

    // byte codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    localparam int FIELD_BITS = 16;

    typedef struct packed {
        logic [FIELD_BITS-1:0] token_offset;
        logic [FIELD_BITS-1:0] token_length;
        logic [FIELD_BITS-1:0] line_number;
        logic [FIELD_BITS-1:0] column_number;
        logic                  is_separator;
        logic                  last_of_run;
    } token_t;

    // tokens produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

// ===== rtl/core/swt_lexer.sv =====
module swt_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    output swt_pkg::push_t      push
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    logic [POSITION_BITS-1:0] pos_reg,        pos_next;
    logic [POSITION_BITS-1:0] line_reg,       line_next;
    logic [POSITION_BITS-1:0] line_begin_reg, line_begin_next;
    logic                     word_open_reg,  word_open_next;
    logic [POSITION_BITS-1:0] word_begin_reg, word_begin_next;
    logic [POSITION_BITS-1:0] count_reg,      count_next;

    logic                     alnum, sep, space, newline, nul;
    logic                     opening, open_now, word_emit;
    logic [POSITION_BITS-1:0] begin_now, count_now;
    logic [POSITION_BITS-1:0] word_col, sep_col, word_diff, sep_diff;
    swt_pkg::token_t          word_tok, sep_tok;

    always_comb
    begin
        alnum   = (text_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
        sep     = (text_byte inside {swt_pkg::CHAR_NL, swt_pkg::CHAR_EQUALS,
                                     swt_pkg::CHAR_LPAREN, swt_pkg::CHAR_RPAREN,
                                     swt_pkg::CHAR_LBRACE, swt_pkg::CHAR_RBRACE,
                                     swt_pkg::CHAR_COMMA});
        space   = (text_byte == swt_pkg::CHAR_SPACE);
        newline = (text_byte == swt_pkg::CHAR_NL);
        nul     = (text_byte == swt_pkg::CHAR_NUL);

        opening   = !word_open_reg && alnum;
        open_now  = word_open_reg || opening;
        begin_now = opening ? pos_reg : word_begin_reg;
        count_now = opening ? '0 : count_reg;
        word_emit = (sep || space) && open_now && (count_now != '0);

        // column is offset - line start + 1, saturating; 1 before the line start
        word_diff = begin_now - line_begin_reg;
        sep_diff  = pos_reg - line_begin_reg;
        if (begin_now < line_begin_reg)
            word_col = POS_ONE;
        else
            word_col = (word_diff == POS_MAX) ? POS_MAX : word_diff + POS_ONE;
        if (pos_reg < line_begin_reg)
            sep_col = POS_ONE;
        else
            sep_col = (sep_diff == POS_MAX) ? POS_MAX : sep_diff + POS_ONE;

        word_tok.token_offset  = swt_pkg::FIELD_BITS'(begin_now);
        word_tok.token_length  = swt_pkg::FIELD_BITS'(count_now);
        word_tok.line_number   = swt_pkg::FIELD_BITS'(line_reg);
        word_tok.column_number = swt_pkg::FIELD_BITS'(word_col);
        word_tok.is_separator  = 1'b0;
        word_tok.last_of_run   = !sep;

        sep_tok.token_offset   = swt_pkg::FIELD_BITS'(pos_reg);
        sep_tok.token_length   = swt_pkg::FIELD_BITS'(1);
        sep_tok.line_number    = swt_pkg::FIELD_BITS'(line_reg);
        sep_tok.column_number  = swt_pkg::FIELD_BITS'(sep_col);
        sep_tok.is_separator   = 1'b1;
        sep_tok.last_of_run    = 1'b1;

        push.first  = word_emit ? word_tok : sep_tok;
        push.second = sep_tok;
        if (!step || nul)
            push.count = 2'd0;
        else if (sep)
            push.count = word_emit ? 2'd2 : 2'd1;
        else if (word_emit)
            push.count = 2'd1;
        else
            push.count = 2'd0;

        word_open_next  = open_now && !sep && !word_emit;
        word_begin_next = begin_now;
        count_next      = count_now;
        if (word_open_next && (count_now != POS_MAX))
            count_next = count_now + POS_ONE;
        pos_next        = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_ONE;
        line_begin_next = line_begin_reg;
        line_next       = line_reg;
        if (newline)
        begin
            line_begin_next = pos_next;
            line_next       = (line_reg == POS_MAX) ? POS_MAX : line_reg + POS_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            line_reg       <= POS_ONE;
            line_begin_reg <= '0;
            word_open_reg  <= 1'b0;
            word_begin_reg <= '0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            if (nul)
            begin
                // end of text: drop any open word, start over
                pos_reg        <= '0;
                line_reg       <= POS_ONE;
                line_begin_reg <= '0;
                word_open_reg  <= 1'b0;
                word_begin_reg <= '0;
                count_reg      <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                line_reg       <= line_next;
                line_begin_reg <= line_begin_next;
                word_open_reg  <= word_open_next;
                word_begin_reg <= word_begin_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

// ===== rtl/core/swt_token_fifo.sv =====
module swt_token_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  swt_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output swt_pkg::token_t out_token
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    swt_pkg::token_t       entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;
    logic                  pop;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;

    always_comb
    begin
        out_valid    = (count_reg != '0);
        out_token    = entry_reg[rd_ptr_reg];
        pop          = out_valid && out_ready;
        // a byte may bring two tokens, so keep two slots free
        room         = (count_reg <= CNT_BITS'(DEPTH - 2));
        wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);
        wr_ptr_next  = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next  = rd_ptr_reg + PTR_BITS'(pop);
        count_next   = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/separator_word_tokenizer.sv =====
// Channel   Dir  Payload
// s_*       in   tdata[7:0] = text_byte
// m_*       out  tdata = offset, length, line, column; tuser = is_separator;
//                tlast = last_of_run
//
// One byte is taken per cycle into an input register, unless a held byte
// waits there; once the queue has two free slots the lexer classifies it,
// updates the counters and pushes 0..2 tokens into a four-entry token queue,
// which drives the output directly. A byte that brings two tokens needs two
// output transfers, so the output port sets the sustained rate.
// Reset (rst_n, async) clears counters, open word and queue.
// A request waits in the input register while the queue has fewer than two
// free slots; s_tready does not depend on m_tready combinationally.
module separator_word_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] token_offset, [31:16] token_length,
                                   // [47:32] line_number, [63:48] column_number
    output logic [0:0]  m_tuser,   // [0] is_separator
    output logic        m_tlast    // last_of_run
);

    logic            in_valid_reg, in_valid_next;
    logic [7:0]      in_byte_reg;
    logic            room, fire, s_accept;
    swt_pkg::push_t  push;
    swt_pkg::token_t out_token;

    always_comb
    begin
        fire          = in_valid_reg && room;
        s_tready      = !in_valid_reg || fire;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept || (in_valid_reg && !fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_byte_reg <= s_tdata;
    end

    swt_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .text_byte (in_byte_reg),
        .push      (push)
    );

    swt_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_token (out_token)
    );

    assign m_tdata = {out_token.column_number, out_token.line_number,
                      out_token.token_length, out_token.token_offset};
    assign m_tuser = out_token.is_separator;
    assign m_tlast = out_token.last_of_run;

`ifndef NO_ASSERTIONS
    // tokens only appear when a byte is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> fire)
        else $error("token pushed without a byte step");

    // a pair is always word then separator, closed by the separator
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.is_separator &&
            push.second.is_separator && push.second.last_of_run &&
            !push.first.last_of_run))
        else $error("bad token pair");

    // end of text emits nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_byte_reg == swt_pkg::CHAR_NUL)) |-> (push.count == 2'd0))
        else $error("token from end-of-text byte");

    // an accepted byte is held for the lexer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> in_valid_reg)
        else $error("accepted byte lost");
`endif

endmodule

// ===== bench/tb_separator_word_tokenizer.sv =====
module tb_separator_word_tokenizer;

    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 900;
    localparam logic [15:0] POS_MAX = 16'hFFFF;
    localparam swt_pkg::token_t NO_TOKEN = '0;

    typedef struct {
        logic [7:0]      text;
        int              golden_count;  // -1: take the predicted tokens
        swt_pkg::token_t golden0;
        swt_pkg::token_t golden1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // tokenizer state as the predictor sees it
    logic [15:0] pos_q;
    logic [15:0] line_q;
    logic [15:0] line_start_q;
    logic        word_open_q;
    logic [15:0] word_start_q;
    logic [15:0] word_len_q;

    swt_pkg::token_t fresh_tokens[$];
    swt_pkg::token_t expected_tokens[$];
    int     error_count = 0;
    bit     tx_quiet = 1'b0;
    bit     rx_quiet = 1'b0;
    bit     hold_request = 1'b0;

    separator_word_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function automatic bit is_alnum(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_delimiter(input logic [7:0] b);
        case (b)
            swt_pkg::CHAR_NL, swt_pkg::CHAR_EQUALS, swt_pkg::CHAR_LPAREN,
            swt_pkg::CHAR_RPAREN, swt_pkg::CHAR_LBRACE, swt_pkg::CHAR_RBRACE,
            swt_pkg::CHAR_COMMA: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic swt_pkg::token_t make_token(input logic [15:0] offset,
                                                   input logic [15:0] length,
                                                   input logic        sep);
        swt_pkg::token_t t;
        t.token_offset  = offset;
        t.token_length  = length;
        t.line_number   = line_q;
        t.column_number = (offset < line_start_q) ? 16'd1 : sat_inc16(offset - line_start_q);
        t.is_separator  = sep;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    function automatic swt_pkg::token_t tok(input int off, input int len, input int line,
                                            input int col, input bit sep, input bit last);
        swt_pkg::token_t t;
        t.token_offset  = off[15:0];
        t.token_length  = len[15:0];
        t.line_number   = line[15:0];
        t.column_number = col[15:0];
        t.is_separator  = sep;
        t.last_of_run   = last;
        return t;
    endfunction

    function automatic void clear_text();
        pos_q        = '0;
        line_q       = 16'd1;
        line_start_q = '0;
        word_open_q  = 1'b0;
        word_start_q = '0;
        word_len_q   = '0;
    endfunction

    // tokens caused by one byte land in fresh_tokens
    function automatic void tokenize_byte(input logic [7:0] b);
        swt_pkg::token_t t;
        fresh_tokens.delete();
        if (b == swt_pkg::CHAR_NUL)
        begin
            clear_text();
            return;
        end
        if (!word_open_q && is_alnum(b))
        begin
            word_open_q  = 1'b1;
            word_start_q = pos_q;
            word_len_q   = '0;
        end
        if (is_delimiter(b))
        begin
            if (word_open_q && word_len_q != 0)
                fresh_tokens.push_back(make_token(word_start_q, word_len_q, 1'b0));
            word_open_q = 1'b0;
            fresh_tokens.push_back(make_token(pos_q, 16'd1, 1'b1));
        end
        else if (b == swt_pkg::CHAR_SPACE && word_open_q && word_len_q != 0)
        begin
            fresh_tokens.push_back(make_token(word_start_q, word_len_q, 1'b0));
            word_open_q = 1'b0;
        end
        if (b == swt_pkg::CHAR_NL)
        begin
            line_start_q = sat_inc16(pos_q);
            line_q       = sat_inc16(line_q);
        end
        if (word_open_q)
            word_len_q = sat_inc16(word_len_q);
        pos_q = sat_inc16(pos_q);
        if (fresh_tokens.size() != 0)
        begin
            t = fresh_tokens.pop_back();
            t.last_of_run = 1'b1;
            fresh_tokens.push_back(t);
        end
    endfunction

    // mostly text-like bytes, with some noise
    function automatic logic [7:0] random_text_byte();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            case ($urandom_range(0, 2))
                0:       b = 8'($urandom_range("0", "9"));
                1:       b = 8'($urandom_range("A", "Z"));
                default: b = 8'($urandom_range("a", "z"));
            endcase
        end
        else if (pick < 55)
            b = swt_pkg::CHAR_SPACE;
        else if (pick < 75)
        begin
            case ($urandom_range(0, 7))
                0, 1:    b = swt_pkg::CHAR_NL;
                2:       b = swt_pkg::CHAR_EQUALS;
                3:       b = swt_pkg::CHAR_LPAREN;
                4:       b = swt_pkg::CHAR_RPAREN;
                5:       b = swt_pkg::CHAR_LBRACE;
                6:       b = swt_pkg::CHAR_RBRACE;
                default: b = swt_pkg::CHAR_COMMA;
            endcase
        end
        else if (pick < 85)
        begin
            b = 8'($urandom_range(33, 126));
            while (is_alnum(b) || is_delimiter(b))
                b = 8'($urandom_range(33, 126));
        end
        else if (pick < 92)
            b = 8'($urandom_range(128, 255));
        else if (pick < 94)
            b = swt_pkg::CHAR_NUL;
        else
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    task automatic send_byte(input logic [7:0] text, input int golden_count,
                             input swt_pkg::token_t golden0, input swt_pkg::token_t golden1);
        int gap;
        @(negedge clk);
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = text;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        tokenize_byte(text);
        if (golden_count < 0)
        begin
            foreach (fresh_tokens[k])
                expected_tokens.push_back(fresh_tokens[k]);
        end
        else
        begin
            if (golden_count >= 1)
                expected_tokens.push_back(golden0);
            if (golden_count >= 2)
                expected_tokens.push_back(golden1);
        end
    endtask

    task automatic send_plain(input logic [7:0] text);
        send_byte(text, -1, NO_TOKEN, NO_TOKEN);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : token_sink
        int              gap;
        swt_pkg::token_t got;
        swt_pkg::token_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap != 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
            got.token_offset  = m_tdata[15:0];
            got.token_length  = m_tdata[31:16];
            got.line_number   = m_tdata[47:32];
            got.column_number = m_tdata[63:48];
            got.is_separator  = m_tuser[0];
            got.last_of_run   = m_tlast;
            if (expected_tokens.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected token expected none, got %p", $time, got);
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_offset", want.token_offset, got.token_offset);
                check_field("token_length", want.token_length, got.token_length);
                check_field("line_number", want.line_number, got.line_number);
                check_field("column_number", want.column_number, got.column_number);
                check_field("is_separator", want.is_separator, got.is_separator);
                check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
        end
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid & s_tready) === 1'b1 || (m_tvalid & m_tready) === 1'b1)
                stalled = 0;
            else
                stalled++;
        end
        $display("separator_word_tokenizer verification failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t rows[25];
        clear_text();
        rows = '{
            '{swt_pkg::CHAR_LPAREN, 1, tok(0, 1, 1, 1, 1, 1), NO_TOKEN},
            '{swt_pkg::CHAR_RPAREN, 1, tok(1, 1, 1, 2, 1, 1), NO_TOKEN},
            '{swt_pkg::CHAR_NL,     1, tok(2, 1, 1, 3, 1, 1), NO_TOKEN},
            '{"Z",                  0, NO_TOKEN, NO_TOKEN},
            '{"9",                 -1, NO_TOKEN, NO_TOKEN},
            '{8'hFF,               -1, NO_TOKEN, NO_TOKEN},   // non-ASCII inside a word
            '{swt_pkg::CHAR_SPACE,  1, tok(3, 3, 2, 1, 0, 1), NO_TOKEN},
            '{8'h80,                0, NO_TOKEN, NO_TOKEN},   // non-ASCII, no word open
            '{"a",                 -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_EQUALS, 2, tok(8, 1, 2, 6, 0, 0), tok(9, 1, 2, 7, 1, 1)},
            '{"0",                 -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_LBRACE,-1, NO_TOKEN, NO_TOKEN},
            '{"z",                 -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_RBRACE,-1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_COMMA, -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_NL,    -1, NO_TOKEN, NO_TOKEN},
            '{"!",                 -1, NO_TOKEN, NO_TOKEN},
            '{"q",                 -1, NO_TOKEN, NO_TOKEN},
            '{".",                 -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_NUL,    0, NO_TOKEN, NO_TOKEN},   // open word is dropped
            '{swt_pkg::CHAR_COMMA,  1, tok(0, 1, 1, 1, 1, 1), NO_TOKEN},
            '{swt_pkg::CHAR_SPACE, -1, NO_TOKEN, NO_TOKEN},
            '{"~",                 -1, NO_TOKEN, NO_TOKEN},
            '{"a",                 -1, NO_TOKEN, NO_TOKEN},
            '{swt_pkg::CHAR_RPAREN,-1, NO_TOKEN, NO_TOKEN}
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[r])
            send_byte(rows[r].text, rows[r].golden_count, rows[r].golden0, rows[r].golden1);
        pause_until_drained();
        send_plain(swt_pkg::CHAR_NUL);

        for (int n = 0; n < RANDOM_BYTES; n++)
        begin
            tx_quiet = (n >= 150 && n < 250) || (n >= 300 && n < 340);
            rx_quiet = (n >= 400 && n < 500);
            if (n == 300)
                hold_request = 1'b1;   // sink stalls while requests keep coming
            if (n == 600)
                pause_until_drained();
            send_plain(random_text_byte());
        end
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("separator_word_tokenizer verification clean");
        else
            $display("separator_word_tokenizer verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/swt_pkg.sv
rtl/core/swt_lexer.sv
rtl/core/swt_token_fifo.sv
rtl/core/separator_word_tokenizer.sv
bench/tb_separator_word_tokenizer.sv
